>>> rtl/text_console_writer_top_defines.svh
// Assertion macros shared by the text console writer RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, quiet while in reset
`define TCW_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while in reset
`define TCW_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// Shared constants, types and address helpers for the text console writer.
// No dependencies; used by tcw_put and text_console_writer_top.
package tcw_pkg;

  // Screen geometry
  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  localparam int RW  = $clog2(ROWS);        // stored row index
  localparam int RWT = $clog2(ROWS + 1);    // row before scroll check
  localparam int CW  = $clog2(COLS);        // stored column index
  localparam int CWT = $clog2(COLS + 8);    // column before wrap check (tab)
  localparam int AW  = $clog2(CELLS);       // cell address

  localparam int CELL_W = 16;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  // Word layouts
  localparam int OP_W         = 2;
  localparam int IN_FIELDS_W  = 8 + 5 + 7;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 5 + 7 + 11 + 8 + 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operations
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Control characters
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  // Outcome of one put: the cell write and the new cursor
  typedef struct packed {
    logic          we;
    logic          wblank;
    logic [CW-1:0] wcol;
    logic [RW-1:0] row_nxt;
    logic [CW-1:0] col_nxt;
    logic          scroll;
  } put_t;

  // Screen row to memory row, rows kept as a ring starting at top
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row);
    logic [RW:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (RW+1)'(ROWS)) sum = sum - (RW+1)'(ROWS);
    return sum[RW-1:0];
  endfunction

  // Row and column to linear cell address
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    return AW'(row) * AW'(COLS) + AW'(col);
  endfunction

endpackage

>>> rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tcw_put.sv
// Cursor engine for one put: control characters, wrap and scroll decision.
// Depends on tcw_pkg.
module tcw_put (
  input  logic [tcw_pkg::RW-1:0] cur_row,
  input  logic [tcw_pkg::CW-1:0] cur_col,
  input  logic [7:0]             char_code,
  output tcw_pkg::put_t          res
);
  import tcw_pkg::*;

  logic [CWT-1:0] col_t;
  logic [RWT-1:0] row_t;

  always_comb begin
    res    = '0;
    col_t  = CWT'(cur_col);
    row_t  = RWT'(cur_row);

    // character decode
    case (char_code)
      CH_NL: begin
        col_t = '0;
        row_t = row_t + RWT'(1);
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_TAB: begin
        col_t = (CWT'(cur_col) + CWT'(8)) & ~CWT'(7);
      end
      CH_BS: begin
        if (cur_col != '0) begin
          col_t      = CWT'(cur_col) - CWT'(1);
          res.we     = 1'b1;
          res.wblank = 1'b1;
          res.wcol   = cur_col - CW'(1);
        end
      end
      default: begin
        res.we   = 1'b1;
        res.wcol = cur_col;
        col_t    = CWT'(cur_col) + CWT'(1);
      end
    endcase

    // wrap past the last column
    if (col_t >= CWT'(COLS)) begin
      col_t = '0;
      row_t = row_t + RWT'(1);
    end

    // past the last row: stay on it and scroll
    res.col_nxt = col_t[CW-1:0];
    if (row_t >= RWT'(ROWS)) begin
      res.scroll  = 1'b1;
      res.row_nxt = RW'(ROWS - 1);
    end else begin
      res.row_nxt = row_t[RW-1:0];
    end
  end

endmodule

>>> rtl/text_console_writer_top.sv
// Text console writer: screen cell memory, cursor, scroll and clear sweeps.
// Depends on tcw_pkg, tcw_ram, tcw_put and text_console_writer_top_defines.svh.
//
//  channel | dir | handshake              | word
//  in_     | in  | in_tvalid / in_tready  | tuser op, tdata char/row/col
//  out_    | out | out_tvalid/out_tready  | tdata cursor and read cell
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data text attribute
//
// Put without scroll, return, tab, unused op: S_DONE. Read: S_READ, then
// S_DONE (the RAM read is registered). A scroll blanks one row in S_SWEEP;
// rows form a ring in the RAM, so no row is copied. Clear sweeps all CELLS.
// After reset a pass over all CELLS cells fills the RAM with blanks before the
// first word is taken. One word is in work at a time; while the output word
// waits the next is still taken, but its result stalls the input in S_DONE.
`include "text_console_writer_top_defines.svh"

module text_console_writer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero pad
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: op[1:0]
  input  logic [tcw_pkg::OP_W-1:0]      in_tuser,
  // out_tdata: cursor_row[4:0], cursor_col[11:5], cursor_pos[22:12],
  //            cell_char[30:23], cell_attr[38:31], zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration: text attribute
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_data
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [RW-1:0]          cur_row_r, cur_row_nxt;
  logic [CW-1:0]          cur_col_r, cur_col_nxt;
  logic [RW-1:0]          top_r, top_nxt;
  logic [AW-1:0]          sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]          sweep_end_r, sweep_end_nxt;
  logic [CELL_W-1:0]      sweep_val_r, sweep_val_nxt;
  logic [7:0]             text_attr_r, text_attr_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0]      cell_r, cell_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                   in_fire;
  logic [OP_W-1:0]        in_op;
  logic [7:0]             in_char;
  logic [4:0]             in_rrow;
  logic [6:0]             in_rcol;
  logic                   rd_ok;
  logic [RW-1:0]          cur_phys;
  logic [AW-1:0]          scroll_base;
  logic [10:0]            pos;
  put_t                   put_res;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [CELL_W-1:0]      mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [CELL_W-1:0]      mem_rdata;

  // input word fields
  assign in_op   = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_rrow = in_tdata[12:8];
  assign in_rcol = in_tdata[19:13];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // cursor engine
  tcw_put u_put (
    .cur_row   (cur_row_r),
    .cur_col   (cur_col_r),
    .char_code (in_char),
    .res       (put_res)
  );

  // cell memory
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // addresses: cursor row and read cell through the row ring
  assign cur_phys    = phys_row(top_r, cur_row_r);
  assign scroll_base = cell_addr(top_r, '0);
  assign rd_ok       = (int'(in_rrow) < ROWS) && (int'(in_rcol) < COLS);
  assign mem_raddr   = rd_ok ? cell_addr(phys_row(top_r, RW'(in_rrow)), CW'(in_rcol))
                             : '0;
  assign pos         = 11'(cell_addr(cur_row_r, cur_col_r));

  // configuration register
  always_comb begin
    text_attr_nxt = text_attr_r;
    if (cfg_valid) text_attr_nxt = cfg_data;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    top_nxt        = top_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_end_nxt  = sweep_end_r;
    sweep_val_nxt  = sweep_val_r;
    rd_ok_nxt      = rd_ok_r;
    cell_nxt       = cell_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r;
    mem_we         = 1'b0;
    mem_waddr      = sweep_addr_r;
    mem_wdata      = sweep_val_r;

    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;

    case (state_r)
      S_INIT, S_SWEEP: begin
        // one blank cell per cycle
        mem_we = 1'b1;
        if (sweep_addr_r == sweep_end_r) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cell_nxt  = '0;
          rd_ok_nxt = rd_ok;
          case (in_op)
            OP_PUT: begin
              mem_we      = put_res.we;
              mem_waddr   = cell_addr(cur_phys, put_res.wcol);
              mem_wdata   = {text_attr_r, put_res.wblank ? CH_SPACE : in_char};
              cur_row_nxt = put_res.row_nxt;
              cur_col_nxt = put_res.col_nxt;
              if (put_res.scroll) begin
                // old top row becomes the blank bottom row
                top_nxt        = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
                sweep_addr_nxt = scroll_base;
                sweep_end_nxt  = scroll_base + AW'(COLS - 1);
                sweep_val_nxt  = {text_attr_r, CH_SPACE};
                state_nxt      = S_SWEEP;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_READ: begin
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              cur_row_nxt    = '0;
              cur_col_nxt    = '0;
              top_nxt        = '0;
              sweep_addr_nxt = '0;
              sweep_end_nxt  = AW'(CELLS - 1);
              sweep_val_nxt  = {text_attr_r, CH_SPACE};
              state_nxt      = S_SWEEP;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        cell_nxt  = rd_ok_r ? mem_rdata : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            cell_r[15:8], cell_r[7:0], pos,
                            7'(cur_col_r), 5'(cur_row_r)};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= AW'(CELLS - 1);
      sweep_val_r  <= RESET_CELL;
      text_attr_r  <= ATTR_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      top_r        <= top_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_end_r  <= sweep_end_nxt;
      sweep_val_r  <= sweep_val_nxt;
      text_attr_r  <= text_attr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ok_r     <= rd_ok_nxt;
    cell_r      <= cell_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // checks
  `TCW_ASSERT_NXT(a_accept_leaves_idle, in_fire, state_r != S_IDLE,
                  "accepted word left block idle")
  `TCW_ASSERT_IMP(a_sweep_in_range, state_r == S_INIT || state_r == S_SWEEP,
                  sweep_addr_r <= sweep_end_r, "sweep ran past its end")
  `TCW_ASSERT_IMP(a_cursor_on_screen, 1'b1,
                  int'(cur_row_r) < ROWS && int'(cur_col_r) < COLS, "cursor off screen")
  `TCW_ASSERT_IMP(a_top_on_screen, 1'b1, int'(top_r) < ROWS, "row ring top out of range")
  `TCW_ASSERT_NXT(a_done_delivers, state_r == S_DONE && (!out_tvalid_r || out_tready),
                  out_tvalid_r && state_r == S_IDLE, "finished word not delivered")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for text_console_writer_top: sends put, read, clear and spare-op words,
// rewrites the text attribute between phases and checks every result word.
// Depends on tcw_pkg and the console writer RTL; the screen is tracked in a class.

module tb_top;
  import tcw_pkg::*;

  // Expected fields of one result word
  typedef struct {
    logic [4:0]  crow;
    logic [6:0]  ccol;
    logic [10:0] cpos;
    logic [7:0]  cchar;
    logic [7:0]  cattr;
  } cursor_word_t;

  // op 3 has no meaning; it only reports the cursor
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Screen and cursor tracker with the queue of awaited result words
  class screen_tracker;
    logic [15:0]  cells [CELLS];
    int unsigned  row, col;
    logic [7:0]   attr;
    cursor_word_t awaited [$];
    int unsigned  mismatches, checked, scrolls, wraps, clears, reads;

    function new();
      for (int i = 0; i < CELLS; i++) cells[i] = RESET_CELL;
      row = 0;
      col = 0;
      attr = ATTR_RESET;
      mismatches = 0;
      checked = 0;
      scrolls = 0;
      wraps = 0;
      clears = 0;
      reads = 0;
    endfunction

    function logic [15:0] blank_cell();
      return {attr, CH_SPACE};
    endfunction

    // One byte through the cursor logic, scroll included
    function void put_char(logic [7:0] c);
      if (c == CH_NL) begin
        col = 0;
        row++;
      end else if (c == CH_CR) begin
        col = 0;
      end else if (c == CH_TAB) begin
        col = (col + 8) & ~32'd7;
      end else if (c == CH_BS) begin
        if (col > 0) begin
          col--;
          cells[row * COLS + col] = blank_cell();
        end
      end else begin
        cells[row * COLS + col] = {attr, c};
        col++;
      end
      if (col >= COLS) begin
        col = 0;
        row++;
        wraps++;
      end
      if (row >= ROWS) begin
        for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = blank_cell();
        row = ROWS - 1;
        scrolls++;
      end
    endfunction

    // Accepted command word: update the screen, queue the result it causes
    function void note_command(logic [1:0] op, logic [7:0] ch, logic [4:0] rr,
                               logic [6:0] rc);
      cursor_word_t w;
      logic [15:0]  v;
      w.cchar = 8'h00;
      w.cattr = 8'h00;
      case (op)
        OP_PUT: put_char(ch);
        OP_READ: begin
          reads++;
          if (rr < ROWS && rc < COLS) begin
            v = cells[int'(rr) * COLS + int'(rc)];
            w.cchar = v[7:0];
            w.cattr = v[15:8];
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < CELLS; i++) cells[i] = blank_cell();
          row = 0;
          col = 0;
          clears++;
        end
        default: ;
      endcase
      w.crow = 5'(row);
      w.ccol = 7'(col);
      w.cpos = 11'((row * COLS + col) & 32'h7FF);
      awaited.push_back(w);
    endfunction

    // Result word against the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] d);
      cursor_word_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %h with nothing awaited", d);
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (d[4:0] !== e.crow || d[11:5] !== e.ccol || d[22:12] !== e.cpos ||
          d[30:23] !== e.cchar || d[38:31] !== e.cattr) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: row %0d/%0d col %0d/%0d pos %0d/%0d",
                    " char %h/%h attr %h/%h (exp/got)"},
                   e.crow, d[4:0], e.ccol, d[11:5], e.cpos, d[22:12],
                   e.cchar, d[30:23], e.cattr, d[38:31]);
      end
    endfunction
  endclass

  // Timeout limit in clock cycles, taken several times over the slowest sane run
  localparam int LIMIT       = 1500000;
  localparam int PHASE_WORDS = 300;
  localparam int LONG_HOLD   = 400;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_data = 8'h00;

  screen_tracker screen = new();
  bit            steady = 1'b0;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;
  int unsigned   sent = 0;
  int unsigned   settings = 0;

  text_console_writer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Offer one command word after a random gap (none in steady mode); valid stays up for the next one
  task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({rc, rr, ch});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    screen.note_command(op, ch, rr, rc);
    sent++;
  endtask

  task automatic stop_and_drain();
    in_tvalid <= 1'b0;
    while (screen.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    screen.attr = v;
    settings++;
  endtask

  // Mostly puts with a mix of control bytes; reads on the cursor row, elsewhere or out of range; spare ops; rare clears
  task automatic run_phase(int n);
    int unsigned pick, sel;
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [4:0]  rr;
    logic [6:0]  rc;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      ch = 8'($urandom);
      rr = 5'($urandom);
      rc = 7'($urandom);
      if (pick < 70) begin
        op = OP_PUT;
        sel = $urandom_range(0, 99);
        if (sel < 5)       ch = CH_NL;
        else if (sel < 8)  ch = CH_CR;
        else if (sel < 13) ch = CH_TAB;
        else if (sel < 20) ch = CH_BS;
        else if (sel >= 35) ch = 8'($urandom_range(32, 126));
      end else if (pick < 94) begin
        op = OP_READ;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          rr = 5'(screen.row);
          rc = 7'($urandom_range(0, COLS - 1));
        end else if (sel < 9) begin
          rr = 5'($urandom_range(0, ROWS - 1));
          rc = 7'($urandom_range(0, COLS - 1));
        end
      end else if (pick < 99) begin
        op = OP_SPARE;
      end else begin
        op = OP_CLEAR;
      end
      send_word(op, ch, rr, rc);
    end
  endtask

  // Result side: random ready gaps, one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        gap = LONG_HOLD;
        hold_done = 1'b1;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      screen.check_result(out_tdata);
    end
  end

  // Timeout
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin
    logic [7:0] a;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset cells, reads out of range, edge bytes, backspace at column 0,
    // tabs, spare op, clear
    send_word(OP_READ, 8'h00, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd24, 7'd79);
    send_word(OP_READ, 8'h00, 5'd25, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd80);
    send_word(OP_READ, 8'hFF, 5'd31, 7'd127);
    send_word(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_word(OP_PUT, 8'hFF, 5'd31, 7'd127);
    send_word(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd1);
    send_word(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd2);
    send_word(OP_PUT, CH_CR, 5'd0, 7'd0);
    send_word(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_PUT, 8'h7E, 5'd0, 7'd0);
    send_word(OP_PUT, CH_NL, 5'd0, 7'd0);
    send_word(OP_SPARE, 8'hFF, 5'd31, 7'd127);
    send_word(OP_READ, 8'h00, 5'd0, 7'd16);
    send_word(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd0);
    send_word(OP_PUT, 8'h55, 5'd0, 7'd0);
    send_word(OP_PUT, 8'hAA, 5'd0, 7'd0);

    // Random phases, one attribute each; a burst phase and a long result hold-off
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: a = 8'hFF;
        1: a = 8'h00;
        2: a = 8'h1E;
        5: a = ATTR_RESET;
        default: a = 8'($urandom);
      endcase
      stop_and_drain();
      write_attr(a);
      steady = (p == 1);
      if (p == 3) hold_req = 1'b1;
      run_phase(PHASE_WORDS);
    end

    stop_and_drain();
    repeat (100) @(posedge clk);

    $display("sent %0d words: %0d reads, %0d clears, %0d line wraps, %0d scrolls",
             sent, screen.reads, screen.clears, screen.wraps, screen.scrolls);
    $display("checked %0d results under %0d attribute settings, %0d mismatches",
             screen.checked, settings, screen.mismatches);
    if (screen.mismatches == 0 && screen.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
